// ----- rtl/smsq_pkg.sv -----
`default_nettype none

package smsq_pkg;

  // sizes
  localparam int SERVO_COUNT = 4;
  localparam int SERVO_W     = $clog2(SERVO_COUNT);
  localparam int ANGLE_W     = 8;
  localparam int REG_COUNT   = 8;
  localparam int REG_W       = $clog2(REG_COUNT);
  localparam int MAX_MOVES   = 6;
  localparam int MOVE_W      = 3;
  localparam int CMD_W       = 3;

  typedef logic [ANGLE_W-1:0]           angle_t;
  typedef logic [SERVO_W-1:0]           servo_t;
  typedef logic [CMD_W-1:0]             cmd_t;
  typedef logic [MOVE_W-1:0]            move_idx_t;
  typedef logic [REG_W-1:0]             reg_idx_t;
  typedef angle_t [REG_COUNT-1:0]       limits_t;

  // register indexes
  localparam reg_idx_t REG_BACK    = 3'd0;
  localparam reg_idx_t REG_FORWARD = 3'd1;
  localparam reg_idx_t REG_RIGHT   = 3'd2;
  localparam reg_idx_t REG_LEFT    = 3'd3;
  localparam reg_idx_t REG_DOWN    = 3'd4;
  localparam reg_idx_t REG_UP      = 3'd5;
  localparam reg_idx_t REG_OPEN    = 3'd6;
  localparam reg_idx_t REG_CLOSED  = 3'd7;

  // limit values after reset, by register index
  localparam limits_t LIMITS_RESET = {
    8'd120,  // closed
    8'd10,   // open
    8'd120,  // up
    8'd10,   // down
    8'd160,  // left
    8'd0,    // right
    8'd130,  // forward
    8'd50    // back
  };

  // servo numbers
  localparam servo_t SERVO_ROT  = 2'd0;
  localparam servo_t SERVO_FB   = 2'd1;
  localparam servo_t SERVO_UD   = 2'd2;
  localparam servo_t SERVO_GRAB = 2'd3;

  // commands, low bits of the command character
  localparam cmd_t CMD_NONE    = 3'd0;
  localparam cmd_t CMD_GRAB    = 3'd1;
  localparam cmd_t CMD_RELEASE = 3'd2;
  localparam cmd_t CMD_UP      = 3'd3;
  localparam cmd_t CMD_DOWN    = 3'd4;
  localparam cmd_t CMD_RIGHT   = 3'd5;
  localparam cmd_t CMD_LEFT    = 3'd6;
  localparam cmd_t CMD_INIT    = 3'd7;

  localparam logic [7:0] CHAR_FIRST = 8'h31;
  localparam logic [7:0] CHAR_LAST  = 8'h37;

  // opcodes
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    servo_t servo;
    angle_t target;
  } move_t;

  typedef struct packed {
    logic   valid;
    servo_t servo;
    angle_t angle;
    logic   done;
  } result_t;

  // floor of the mean of two angles
  function automatic angle_t mid_angle(angle_t a, angle_t b);
    logic [ANGLE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ANGLE_W:1];
  endfunction

  // servo and target of one move of a command
  function automatic move_t move_target(cmd_t cmd, move_idx_t idx, limits_t lim);
    move_t      m;
    logic [1:0] sh;
    sh = (idx < 3'd2) ? 2'd2 : ((idx < 3'd4) ? 2'd1 : 2'd0);
    m  = '0;
    unique case (cmd)
      CMD_GRAB: begin
        m.servo  = SERVO_GRAB;
        m.target = lim[REG_CLOSED];
      end
      CMD_RELEASE: begin
        m.servo  = SERVO_GRAB;
        m.target = lim[REG_OPEN];
      end
      CMD_UP: begin
        if (!idx[0]) begin
          m.servo  = SERVO_UD;
          m.target = lim[REG_UP] >> sh;
        end else begin
          m.servo  = SERVO_FB;
          m.target = lim[REG_BACK] >> sh;
        end
      end
      CMD_DOWN: begin
        if (!idx[0]) begin
          m.servo  = SERVO_UD;
          m.target = lim[REG_DOWN] >> sh;
        end else begin
          m.servo  = SERVO_FB;
          m.target = lim[REG_FORWARD] >> sh;
        end
      end
      CMD_RIGHT: begin
        m.servo  = SERVO_ROT;
        m.target = lim[REG_RIGHT];
      end
      CMD_LEFT: begin
        m.servo  = SERVO_ROT;
        m.target = lim[REG_LEFT];
      end
      CMD_INIT: begin
        unique case (idx)
          3'd0: begin
            m.servo  = SERVO_ROT;
            m.target = mid_angle(lim[REG_RIGHT], lim[REG_LEFT]);
          end
          3'd1: begin
            m.servo  = SERVO_GRAB;
            m.target = lim[REG_OPEN];
          end
          3'd2: begin
            m.servo  = SERVO_FB;
            m.target = mid_angle(lim[REG_FORWARD], lim[REG_BACK]);
          end
          default: begin
            m.servo  = SERVO_UD;
            m.target = mid_angle(lim[REG_UP], lim[REG_DOWN]);
          end
        endcase
      end
      default: m = '0;
    endcase
    return m;
  endfunction

  // number of moves in a command
  function automatic move_idx_t move_count(cmd_t cmd);
    move_idx_t n;
    unique case (cmd) inside
      CMD_GRAB, CMD_RELEASE, CMD_RIGHT, CMD_LEFT: n = 3'd1;
      CMD_UP, CMD_DOWN:                           n = 3'd6;
      CMD_INIT:                                   n = 3'd4;
      default:                                    n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/smsq_cfg_regs.sv -----
`default_nettype none

module smsq_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire smsq_pkg::reg_idx_t addr,
  input  wire smsq_pkg::angle_t  data,
  output smsq_pkg::limits_t      limits
);
  import smsq_pkg::*;

  // limit register file
  always_ff @(posedge clk) begin
    if (rst) begin
      limits <= LIMITS_RESET;
    end else if (we) begin
      limits[addr] <= data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/smsq_core.sv -----
`default_nettype none

module smsq_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              opcode,
  input  wire logic [7:0]        command_byte,
  input  wire smsq_pkg::limits_t limits,
  output smsq_pkg::result_t      result
);
  import smsq_pkg::*;

  angle_t    positions [SERVO_COUNT];
  angle_t    positions_next [SERVO_COUNT];
  cmd_t      active_command;
  move_idx_t move_index;
  logic      busy;
  logic      ramp_started;
  angle_t    ramp_angle;

  cmd_t      cmd_next;
  move_idx_t idx_next;
  logic      busy_next;
  logic      started_next;
  angle_t    ramp_next;

  logic      new_cmd;
  move_t     moves [MAX_MOVES];
  move_t     cur_move;
  angle_t    cur_angle;
  logic      do_skip;
  move_idx_t skip_start;
  move_idx_t count;
  logic      found;

  // command decode, a new list only while idle
  always_comb begin
    new_cmd  = step && (opcode == OP_CMD) && !busy &&
               (command_byte >= CHAR_FIRST) && (command_byte <= CHAR_LAST);
    cmd_next = new_cmd ? command_byte[CMD_W-1:0] : active_command;
  end

  // targets of every move of the selected list
  always_comb begin
    for (int i = 0; i < MAX_MOVES; i++) begin
      moves[i] = move_target(cmd_next, MOVE_W'(i), limits);
    end
  end

  // ramp step, then search for the next move not yet in place
  always_comb begin
    positions_next = positions;
    ramp_next      = ramp_angle;
    started_next   = ramp_started;
    busy_next      = busy;
    idx_next       = move_index;
    result         = '0;
    do_skip        = 1'b0;
    skip_start     = '0;
    cur_move       = moves[move_index];
    cur_angle      = ramp_started ? ramp_angle : positions[cur_move.servo];
    count          = move_count(cmd_next);
    found          = 1'b0;

    if (new_cmd) begin
      started_next = 1'b0;
      do_skip      = 1'b1;
    end else if (step && (opcode == OP_TICK) && busy) begin
      result.valid = 1'b1;
      result.servo = cur_move.servo;
      result.angle = cur_angle;
      if (cur_angle == cur_move.target) begin
        positions_next[cur_move.servo] = cur_move.target;
        started_next = 1'b0;
        do_skip      = 1'b1;
        skip_start   = move_index + 3'd1;
      end else begin
        started_next = 1'b1;
        ramp_next    = (cur_move.target > cur_angle) ? cur_angle + 8'd1
                                                     : cur_angle - 8'd1;
      end
    end

    if (do_skip) begin
      idx_next = count;
      for (int i = 0; i < MAX_MOVES; i++) begin
        if (!found && (MOVE_W'(i) >= skip_start) && (MOVE_W'(i) < count) &&
            (moves[i].target != positions_next[moves[i].servo])) begin
          found    = 1'b1;
          idx_next = MOVE_W'(i);
        end
      end
      busy_next = found;
    end

    result.done = result.valid && do_skip && !found;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        positions[i] <= '0;
      end
      active_command <= CMD_NONE;
      move_index     <= '0;
      busy           <= 1'b0;
      ramp_started   <= 1'b0;
      ramp_angle     <= '0;
    end else begin
      positions      <= positions_next;
      active_command <= cmd_next;
      move_index     <= idx_next;
      busy           <= busy_next;
      ramp_started   <= started_next;
      ramp_angle     <= ramp_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/servo_motion_sequencer.sv -----
// An accepted word waits in the input register, the sequencer processes it, and its result
// word is registered in the output register, where the receiver can take it.
// Throughput: one input word per cycle while the input is not stalled, set by the single sequencer stage.
// Input stalls only while the input register is full and the output word is stalled.
// Reset: limits return to their defaults, all servo positions to zero, idle.
`default_nettype none

module servo_motion_sequencer (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  opcode,
  input  wire logic [7:0]            command_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output smsq_pkg::servo_t           servo_index,
  output smsq_pkg::angle_t           angle_out,
  output logic                       sequence_done,
  input  wire logic                  cfg_we,
  input  wire smsq_pkg::reg_idx_t    cfg_addr,
  input  wire smsq_pkg::angle_t      cfg_data
);
  import smsq_pkg::*;

  limits_t    limits;
  result_t    result;
  logic       s1_valid;
  logic       s1_opcode;
  logic [7:0] s1_byte;
  logic       accept;
  logic       fire;

  smsq_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .we     (cfg_we),
    .addr   (cfg_addr),
    .data   (cfg_data),
    .limits (limits)
  );

  // handshake
  assign fire     = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_opcode <= opcode;
      s1_byte   <= command_byte;
    end
  end

  smsq_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (fire),
    .opcode       (s1_opcode),
    .command_byte (s1_byte),
    .limits       (limits),
    .result       (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && result.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire && result.valid) begin
      servo_index   <= result.servo;
      angle_out     <= result.angle;
      sequence_done <= result.done;
    end
  end

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked output word");

  a_cmd_no_word: assert property (@(posedge clk) disable iff (rst)
    (fire && (s1_opcode == OP_CMD)) |=> !out_valid)
    else $error("command word left a result on the output");

  a_tick_only: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (fire && (s1_opcode == OP_TICK)))
    else $error("result produced by something other than a tick");

endmodule

`default_nettype wire

// ----- dv/servo_motion_sequencer_test.sv -----
`default_nettype none

module servo_motion_sequencer_test;
  import smsq_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_WORDS  = 100;
  localparam int PHASE_COUNT  = 16;
  localparam int TIMEOUT      = 6000000;

  // kinds of limit settings used by the random phases
  typedef enum int {
    SET_DEFAULT,
    SET_FLOOR,
    SET_CEILING,
    SET_FULL_SCALE,
    SET_CORNERS,
    SET_SPREAD,
    SET_CLUSTER,
    SET_OVERRANGE
  } limit_set_t;

  typedef struct packed {
    servo_t servo;
    angle_t angle;
    logic   done;
  } servo_step_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  logic     opcode = OP_TICK;
  logic [7:0] command_byte = 8'h00;
  logic     out_valid;
  logic     out_stall = 1'b0;
  servo_t   servo_index;
  angle_t   angle_out;
  logic     sequence_done;
  logic     cfg_we = 1'b0;
  reg_idx_t cfg_addr = REG_BACK;
  angle_t   cfg_data = 8'd0;

  // idling mix, in percent per cycle
  int gap_pct;
  int stall_pct;

  int errors;
  int words_sent;
  int ticks_sent;
  int angles_checked;
  int settings_used;

  // predictor state
  limits_t     limit_reg;
  angle_t      servo_pos [SERVO_COUNT];
  cmd_t        seq_cmd;
  move_idx_t   seq_move;
  bit          seq_busy;
  bit          ramp_live;
  angle_t      ramp_angle;
  servo_step_t expected_steps [$];

  servo_motion_sequencer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .command_byte (command_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .servo_index  (servo_index),
    .angle_out    (angle_out),
    .sequence_done(sequence_done),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // limit values after reset
  function automatic angle_t default_limit(reg_idx_t i);
    case (i)
      REG_BACK:    return 8'd50;
      REG_FORWARD: return 8'd130;
      REG_RIGHT:   return 8'd0;
      REG_LEFT:    return 8'd160;
      REG_DOWN:    return 8'd10;
      REG_UP:      return 8'd120;
      REG_OPEN:    return 8'd10;
      default:     return 8'd120;
    endcase
  endfunction

  function automatic void reset_predictor();
    for (int i = 0; i < REG_COUNT; i++) limit_reg[i] = default_limit(reg_idx_t'(i));
    for (int i = 0; i < SERVO_COUNT; i++) servo_pos[i] = 8'd0;
    seq_cmd    = CMD_NONE;
    seq_move   = 3'd0;
    seq_busy   = 1'b0;
    ramp_live  = 1'b0;
    ramp_angle = 8'd0;
  endfunction

  function automatic int moves_in(cmd_t c);
    case (c)
      CMD_GRAB, CMD_RELEASE, CMD_RIGHT, CMD_LEFT: return 1;
      CMD_UP, CMD_DOWN:                           return 6;
      CMD_INIT:                                   return 4;
      default:                                    return 0;
    endcase
  endfunction

  // servo and target angle of one move, from the current limits
  function automatic void move_goal(input cmd_t c, input move_idx_t m,
                                    output servo_t s, output angle_t t);
    int scale;
    int a;
    scale = (m < 3'd2) ? 4 : ((m < 3'd4) ? 2 : 1);
    s = SERVO_ROT;
    a = 0;
    case (c)
      CMD_GRAB: begin
        s = SERVO_GRAB;
        a = int'(limit_reg[REG_CLOSED]);
      end
      CMD_RELEASE: begin
        s = SERVO_GRAB;
        a = int'(limit_reg[REG_OPEN]);
      end
      CMD_UP: begin
        if (m[0]) begin
          s = SERVO_FB;
          a = int'(limit_reg[REG_BACK]) / scale;
        end else begin
          s = SERVO_UD;
          a = int'(limit_reg[REG_UP]) / scale;
        end
      end
      CMD_DOWN: begin
        if (m[0]) begin
          s = SERVO_FB;
          a = int'(limit_reg[REG_FORWARD]) / scale;
        end else begin
          s = SERVO_UD;
          a = int'(limit_reg[REG_DOWN]) / scale;
        end
      end
      CMD_RIGHT: a = int'(limit_reg[REG_RIGHT]);
      CMD_LEFT:  a = int'(limit_reg[REG_LEFT]);
      CMD_INIT: begin
        case (m)
          3'd0: a = (int'(limit_reg[REG_RIGHT]) + int'(limit_reg[REG_LEFT])) / 2;
          3'd1: begin
            s = SERVO_GRAB;
            a = int'(limit_reg[REG_OPEN]);
          end
          3'd2: begin
            s = SERVO_FB;
            a = (int'(limit_reg[REG_FORWARD]) + int'(limit_reg[REG_BACK])) / 2;
          end
          default: begin
            s = SERVO_UD;
            a = (int'(limit_reg[REG_UP]) + int'(limit_reg[REG_DOWN])) / 2;
          end
        endcase
      end
      default: a = 0;
    endcase
    t = angle_t'(a);
  endfunction

  // pass over moves whose servo already sits at the target
  function automatic void skip_settled_moves();
    servo_t s;
    angle_t t;
    while (int'(seq_move) < moves_in(seq_cmd)) begin
      move_goal(seq_cmd, seq_move, s, t);
      if (t != servo_pos[s]) break;
      seq_move++;
    end
    if (int'(seq_move) >= moves_in(seq_cmd)) seq_busy = 1'b0;
  endfunction

  // advance the predictor by one accepted word
  function automatic void predict_word(input logic op, input logic [7:0] b);
    servo_t      s;
    angle_t      t;
    servo_step_t step;
    if (op == OP_CMD) begin
      if (!seq_busy && b >= CHAR_FIRST && b <= CHAR_LAST) begin
        seq_cmd   = cmd_t'(b[CMD_W-1:0]);
        seq_move  = 3'd0;
        seq_busy  = 1'b1;
        ramp_live = 1'b0;
        skip_settled_moves();
      end
    end else if (seq_busy) begin
      move_goal(seq_cmd, seq_move, s, t);
      if (!ramp_live) begin
        ramp_angle = servo_pos[s];
        ramp_live  = 1'b1;
      end
      step.servo = s;
      step.angle = ramp_angle;
      step.done  = 1'b0;
      if (ramp_angle == t) begin
        servo_pos[s] = t;
        ramp_live    = 1'b0;
        seq_move++;
        skip_settled_moves();
        step.done = !seq_busy;
      end else if (t > ramp_angle) begin
        ramp_angle++;
      end else begin
        ramp_angle--;
      end
      expected_steps.push_back(step);
    end
  endfunction

  function automatic logic [7:0] command_char(cmd_t c);
    return CHAR_FIRST + 8'(c) - 8'd1;
  endfunction

  // send one word; valid stays high afterwards until the next word or a drain
  task automatic send_word(input logic op, input logic [7:0] b);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    command_byte <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (op == OP_TICK) ticks_sent++;
    predict_word(op, b);
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 8'($urandom_range(255)));
  endtask

  task automatic tick_until_idle();
    while (seq_busy) send_tick();
  endtask

  // stop sending and let every pending angle come out
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input reg_idx_t i, input angle_t v);
    cfg_we   <= 1'b1;
    cfg_addr <= i;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    limit_reg[i] = v;
    @(posedge clk);
  endtask

  task automatic load_limits(input limits_t set);
    drain();
    for (int i = 0; i < REG_COUNT; i++) write_limit(reg_idx_t'(i), set[i]);
    settings_used++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
    end
  endtask

  // compare each output word with the oldest predicted step
  always @(posedge clk) begin : check_results
    servo_step_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual servo %0d angle %0d done %0d",
                 $realtime, servo_index, angle_out, sequence_done);
      end else begin
        want = expected_steps.pop_front();
        angles_checked++;
        check_field("servo_index", want.servo, servo_index);
        check_field("angle_out", want.angle, angle_out);
        check_field("sequence_done", want.done, sequence_done);
      end
    end
  end

  // ticks while idle, bytes next to the command range, a command that is already settled
  task automatic test_idle_inputs();
    send_tick();
    send_word(OP_CMD, CHAR_FIRST - 8'd1);
    send_word(OP_CMD, CHAR_LAST + 8'd1);
    send_word(OP_CMD, 8'hff);
    send_word(OP_CMD, command_char(CMD_RIGHT));
    send_tick();
  endtask

  // small limits so that each ramp is a few words long; a command while busy is dropped
  task automatic test_single_moves();
    limits_t set;
    set[REG_BACK]    = 8'd0;
    set[REG_FORWARD] = 8'd0;
    set[REG_RIGHT]   = 8'd0;
    set[REG_LEFT]    = 8'd2;
    set[REG_DOWN]    = 8'd0;
    set[REG_UP]      = 8'd2;
    set[REG_OPEN]    = 8'd1;
    set[REG_CLOSED]  = 8'd2;
    load_limits(set);
    send_word(OP_CMD, command_char(CMD_GRAB));
    send_tick();
    send_word(OP_CMD, command_char(CMD_RELEASE));
    tick_until_idle();
  endtask

  // up list whose arm moves, the last one among them, are all settled
  task automatic test_trailing_skips();
    send_word(OP_CMD, command_char(CMD_UP));
    tick_until_idle();
  endtask

  // target pulled back under a running ramp
  task automatic test_limit_change_mid_ramp();
    send_word(OP_CMD, command_char(CMD_LEFT));
    send_tick();
    drain();
    write_limit(REG_LEFT, 8'd0);
    tick_until_idle();
  endtask

  task automatic test_down_and_initial();
    send_word(OP_CMD, command_char(CMD_DOWN));
    tick_until_idle();
    send_word(OP_CMD, command_char(CMD_INIT));
    tick_until_idle();
  endtask

  // mostly complete command runs with random limits, plus dropped and unknown bytes
  task automatic test_random_traffic();
    limits_t    set;
    limit_set_t kind;
    angle_t     base;
    int         counted;
    int         r;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph == PHASE_COUNT * 3 / 8) begin
        gap_pct   = 85;
        stall_pct = 8;
      end else if (ph == PHASE_COUNT * 11 / 16) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      case (ph)
        0:       kind = SET_DEFAULT;
        1:       kind = SET_FLOOR;
        2:       kind = SET_CEILING;
        3:       kind = SET_FULL_SCALE;
        4:       kind = SET_CORNERS;
        default: begin
          r    = $urandom_range(9);
          kind = (r < 3) ? SET_SPREAD : ((r < 8) ? SET_CLUSTER : SET_OVERRANGE);
        end
      endcase
      base = angle_t'($urandom_range(174));
      for (int i = 0; i < REG_COUNT; i++) begin
        case (kind)
          SET_DEFAULT:    set[i] = default_limit(reg_idx_t'(i));
          SET_FLOOR:      set[i] = 8'd0;
          SET_CEILING:    set[i] = 8'd180;
          SET_FULL_SCALE: set[i] = 8'd255;
          SET_CORNERS:    set[i] = $urandom_range(1) ? 8'd180 : 8'd0;
          SET_SPREAD:     set[i] = angle_t'($urandom_range(180));
          SET_CLUSTER:    set[i] = base + angle_t'($urandom_range(6));
          default:        set[i] = angle_t'($urandom_range(255));
        endcase
      end
      load_limits(set);
      counted = 0;
      while (counted < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (!seq_busy) begin
          if (r < 80) begin
            send_word(OP_CMD, CHAR_FIRST + 8'($urandom_range(6)));
            counted++;
          end else if (r < 92) begin
            send_word(OP_CMD, 8'($urandom_range(255)));
          end else begin
            send_tick();
          end
        end else begin
          if (r < 93) begin
            send_tick();
            counted++;
          end else if (r < 97) begin
            send_word(OP_CMD, CHAR_FIRST + 8'($urandom_range(6)));
          end else begin
            send_word(OP_CMD, 8'($urandom_range(255)));
          end
        end
      end
    end
  endtask

  initial begin
    errors         = 0;
    words_sent     = 0;
    ticks_sent     = 0;
    angles_checked = 0;
    settings_used  = 0;
    gap_pct        = 8;
    stall_pct      = 85;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_inputs();
    test_single_moves();
    test_trailing_skips();
    test_limit_change_mid_ramp();
    test_down_and_initial();
    test_random_traffic();
    drain();
    $display("sent %0d words (%0d ticks) under %0d limit settings and three idling mixes",
             words_sent, ticks_sent, settings_used);
    $display("compared %0d servo angles, %0d mismatches", angles_checked, errors);
    if (errors == 0) begin
      $display("servo_motion_sequencer verification clean");
    end else begin
      $display("servo_motion_sequencer verification failed");
    end
    $finish;
  end

  // run time limit
  initial begin
    #TIMEOUT;
    $display("servo_motion_sequencer verification failed");
    $finish;
  end

endmodule

`default_nettype wire
